### sv/isq_pkg.sv
package isq_pkg;

  localparam int CAPACITY   = 64;
  localparam int WORD_BITS  = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  localparam int TYPE_W   = 2;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 7;

  typedef enum logic [TYPE_W-1:0] {
    REQ_READ   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_APPEND = 2'd2,
    REQ_DELETE = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDATA,
    ST_RD,
    ST_WR,
    ST_PUT,
    ST_FINISH
  } state_t;

endpackage

### sv/isq_if.sv
interface isq_in_if;
  logic                          valid;
  logic                          ready;
  logic [isq_pkg::TYPE_W-1:0]    req_type;
  logic [isq_pkg::POS_W-1:0]     position;
  logic [isq_pkg::DATA_W-1:0]    word_in;

  modport source (output valid, req_type, position, word_in, input ready);
  modport sink   (input valid, req_type, position, word_in, output ready);
endinterface

interface isq_out_if;
  logic                          valid;
  logic                          ready;
  logic [isq_pkg::STATUS_W-1:0]  status;
  logic [isq_pkg::DATA_W-1:0]    word_out;
  logic [isq_pkg::ENTRY_W-1:0]   entry_count;
  logic                          is_empty;

  modport source (output valid, status, word_out, entry_count, is_empty, input ready);
  modport sink   (input valid, status, word_out, entry_count, is_empty, output ready);
endinterface

### sv/isq_ram.sv
module isq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/indexed_sequence_store.sv
// channel  dir  fields                                       handshake
// req      in   req_type, position, word_in                  valid/ready
// rsp      out  status, word_out, entry_count, is_empty      valid/ready
//
// One word at a time, through a single RAM with one write and one registered read port.
// Read: data taken in ST_RDATA. Append: written in ST_PUT. Failed checks go straight to ST_FINISH.
// Insert/delete: each entry moved is a RAM read (ST_RD) then write (ST_WR); insert ends in ST_PUT.
// Reset empties the store at once; slot contents are not cleared.
// req.ready is high only while idle; a result waits in the output register while rsp stalls.
module indexed_sequence_store (
  input  logic           clk,
  input  logic           rst,
  isq_in_if.sink         req,
  isq_out_if.source      rsp
);
  import isq_pkg::*;

  state_t                state, state_next;
  req_kind_t             kind, kind_next;
  logic [ADDR_BITS-1:0]  pos, pos_next;
  logic [ADDR_BITS-1:0]  idx, idx_next;
  logic [WORD_BITS-1:0]  word, word_next;
  logic [COUNT_BITS-1:0] count, count_next;
  status_t               res_status, res_status_next;
  logic [WORD_BITS-1:0]  res_word, res_word_next;

  logic                  out_valid, out_valid_next;
  status_t               out_status, out_status_next;
  logic [WORD_BITS-1:0]  out_word, out_word_next;
  logic [COUNT_BITS-1:0] out_count, out_count_next;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

  logic [COUNT_BITS-1:0] in_pos;
  logic [COUNT_BITS-1:0] idx_ext;
  req_kind_t             in_kind;

  isq_ram #(.WIDTH(WORD_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.word_out    = DATA_W'(out_word);
  assign rsp.entry_count = ENTRY_W'(out_count);
  assign rsp.is_empty    = (out_count == '0);

  assign in_pos  = COUNT_BITS'(req.position);
  assign in_kind = req_kind_t'(req.req_type);
  assign idx_ext = COUNT_BITS'(idx);

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    pos_next        = pos;
    idx_next        = idx;
    word_next       = word;
    count_next      = count;
    res_status_next = res_status;
    res_word_next   = res_word;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_word_next   = out_word;
    out_count_next  = out_count;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = ram_rdata;
    ram_raddr       = idx;

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          kind_next       = in_kind;
          pos_next        = ADDR_BITS'(req.position);
          word_next       = WORD_BITS'(req.word_in);
          res_status_next = STS_OK;
          res_word_next   = '0;
          state_next      = ST_FINISH;
          case (in_kind)
            REQ_READ: begin
              if (in_pos >= count) begin
                res_status_next = STS_RANGE;
              end else begin
                ram_raddr  = ADDR_BITS'(req.position);
                state_next = ST_RDATA;
              end
            end
            REQ_INSERT: begin
              if (in_pos != '0 && in_pos >= count) begin
                res_status_next = STS_RANGE;
              end else if (count == COUNT_BITS'(CAPACITY)) begin
                res_status_next = STS_FULL;
              end else begin
                idx_next   = ADDR_BITS'(count);
                state_next = (in_pos == count) ? ST_PUT : ST_RD;
              end
            end
            REQ_APPEND: begin
              if (count == COUNT_BITS'(CAPACITY)) begin
                res_status_next = STS_FULL;
              end else begin
                pos_next   = ADDR_BITS'(count);
                state_next = ST_PUT;
              end
            end
            REQ_DELETE: begin
              if (in_pos >= count) begin
                res_status_next = STS_RANGE;
              end else begin
                idx_next = ADDR_BITS'(req.position);
                if (in_pos + COUNT_BITS'(1) < count) begin
                  state_next = ST_RD;
                end else begin
                  count_next = count - COUNT_BITS'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RDATA: begin
        res_word_next = ram_rdata;
        state_next    = ST_FINISH;
      end
      ST_RD: begin
        ram_raddr  = (kind == REQ_INSERT) ? idx - ADDR_BITS'(1) : idx + ADDR_BITS'(1);
        state_next = ST_WR;
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if (kind == REQ_INSERT) begin
          idx_next   = idx - ADDR_BITS'(1);
          state_next = (idx - ADDR_BITS'(1) == pos) ? ST_PUT : ST_RD;
        end else begin
          idx_next = idx + ADDR_BITS'(1);
          if (idx_ext + COUNT_BITS'(2) < count) begin
            state_next = ST_RD;
          end else begin
            count_next = count - COUNT_BITS'(1);
            state_next = ST_FINISH;
          end
        end
      end
      ST_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = pos;
        ram_wdata  = word;
        count_next = count + COUNT_BITS'(1);
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_word_next   = res_word;
          out_count_next  = count;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    kind       <= kind_next;
    pos        <= pos_next;
    idx        <= idx_next;
    word       <= word_next;
    res_status <= res_status_next;
    res_word   <= res_word_next;
    out_status <= out_status_next;
    out_word   <= out_word_next;
    out_count  <= out_count_next;
  end

endmodule

### sim/tb_indexed_sequence_store.sv
`timescale 1ns / 100ps

module tb_indexed_sequence_store;
  import isq_pkg::*;

  typedef struct {
    req_kind_t          kind;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  word;
    bit                 hold;
  } req_item_t;

  typedef struct {
    status_t             status;
    logic [DATA_W-1:0]   word;
    logic [ENTRY_W-1:0]  count;
    logic                empty;
  } reply_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_GROW, PH_SHRINK, PH_MIX} phase_t;

  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int STALL_AT     = 500;
  localparam int STALL_LEN    = 300;

  logic clk;
  logic rst;

  isq_in_if  req_if ();
  isq_out_if rsp_if ();

  indexed_sequence_store i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  req_item_t item_q[$];
  reply_t    reply_q[$];

  logic [WORD_BITS-1:0] store_words [CAPACITY];
  int                   store_count;
  int                   gen_count;
  int                   issued;
  int                   accepted;
  int                   replies;
  int                   fail_count;

  // driver state
  req_item_t cur_item;
  bit        req_busy;
  int        req_gap;
  bit        req_quiet;

  // monitor state
  int        rsp_wait;
  int        rsp_stretch;
  bit        rsp_quiet;
  reply_t    exp_reply;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  // Store model: applies one request and returns the reply it gives.
  task automatic update_store(input req_item_t it, output reply_t r);
    int i;
    r.status = STS_OK;
    r.word   = '0;
    case (it.kind)
      REQ_READ: begin
        if (it.pos >= store_count) r.status = STS_RANGE;
        else r.word = store_words[it.pos];
      end
      REQ_INSERT: begin
        if (it.pos != 0 && it.pos >= store_count) begin
          r.status = STS_RANGE;
        end else if (store_count >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          for (i = store_count; i > it.pos; i--) store_words[i] = store_words[i-1];
          store_words[it.pos] = it.word[WORD_BITS-1:0];
          store_count++;
        end
      end
      REQ_APPEND: begin
        if (store_count >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          store_words[store_count] = it.word[WORD_BITS-1:0];
          store_count++;
        end
      end
      default: begin
        if (it.pos >= store_count) begin
          r.status = STS_RANGE;
        end else begin
          for (i = it.pos; i + 1 < store_count; i++) store_words[i] = store_words[i+1];
          store_count--;
        end
      end
    endcase
    r.count = store_count[ENTRY_W-1:0];
    r.empty = (store_count == 0);
  endtask

  // Queue an item and track the count it leaves behind.
  task automatic add_item(input req_kind_t kind, input int pos, input logic [DATA_W-1:0] word,
                          input bit hold);
    req_item_t it;
    it.kind = kind;
    it.pos  = pos[POS_W-1:0];
    it.word = word;
    it.hold = hold;
    item_q.push_back(it);
    issued++;
    case (kind)
      REQ_INSERT: if ((it.pos == 0 || it.pos < gen_count) && gen_count < CAPACITY) gen_count++;
      REQ_APPEND: if (gen_count < CAPACITY) gen_count++;
      REQ_DELETE: if (it.pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic int pick_pos();
    if ($urandom_range(0, 11) == 0) return $urandom_range(0, (1 << POS_W) - 1);
    if (gen_count == 0) return 0;
    return $urandom_range(0, gen_count - 1);
  endfunction

  task automatic gen_phase(input phase_t ph, input int len, input bit hold);
    int add_pct;
    int del_pct;
    int r;
    int n;
    req_kind_t kind;
    case (ph)
      PH_FILL:   begin add_pct = 95; del_pct = 0;  end
      PH_DRAIN:  begin add_pct = 0;  del_pct = 95; end
      PH_GROW:   begin add_pct = 60; del_pct = 20; end
      PH_SHRINK: begin add_pct = 20; del_pct = 60; end
      default:   begin add_pct = 35; del_pct = 35; end
    endcase
    for (n = 0; n < len; n++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) kind = ($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_APPEND;
      else if (r < add_pct + del_pct) kind = REQ_DELETE;
      else kind = REQ_READ;
      add_item(kind, pick_pos(), $urandom, hold && n == 0);
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      req_busy = 1'b0;
      req_gap  = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        update_store(cur_item, exp_reply);
        reply_q.push_back(exp_reply);
        accepted++;
        req_busy = 1'b0;
        if (accepted % 64 == 0) req_quiet = ($urandom_range(0, 2) == 0);
        req_gap = draw_gap(req_quiet);
      end
      if (!req_busy) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (item_q.size() > 0 && !(item_q[0].hold && reply_q.size() != 0)) begin
          cur_item = item_q.pop_front();
          req_if.req_type <= cur_item.kind;
          req_if.position <= cur_item.pos;
          req_if.word_in  <= cur_item.word;
          req_busy = 1'b1;
        end
      end
      req_if.valid <= req_busy;
    end
  end

  // Reply monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      rsp_wait    = 0;
      rsp_stretch = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (reply_q.size() == 0) begin
          $error("unexpected reply: status %0d word_out %h entry_count %0d",
                 rsp_if.status, rsp_if.word_out, rsp_if.entry_count);
          fail_count++;
        end else begin
          exp_reply = reply_q.pop_front();
          if (rsp_if.status !== exp_reply.status) begin
            $error("status: expected %0d, got %0d", exp_reply.status, rsp_if.status);
            fail_count++;
          end
          if (rsp_if.word_out !== exp_reply.word) begin
            $error("word_out: expected %h, got %h", exp_reply.word, rsp_if.word_out);
            fail_count++;
          end
          if (rsp_if.entry_count !== exp_reply.count) begin
            $error("entry_count: expected %0d, got %0d", exp_reply.count, rsp_if.entry_count);
            fail_count++;
          end
          if (rsp_if.is_empty !== exp_reply.empty) begin
            $error("is_empty: expected %0d, got %0d", exp_reply.empty, rsp_if.is_empty);
            fail_count++;
          end
        end
        replies++;
        if (replies == STALL_AT) rsp_stretch = STALL_LEN;
        if (replies % 50 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
        rsp_wait = draw_gap(rsp_quiet);
      end
      if (rsp_stretch > 0) begin
        rsp_stretch--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n;
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_READ;
    req_if.position = '0;
    req_if.word_in  = '0;
    rsp_if.ready    = 1'b0;
    store_count = 0;
    gen_count   = 0;
    issued      = 0;
    accepted    = 0;
    replies     = 0;
    fail_count  = 0;
    req_quiet   = 1'b0;
    rsp_quiet   = 1'b0;

    // empty store, bad indexes, insert at head, insert at count, append
    add_item(REQ_READ,   0,  32'h0, 1'b0);
    add_item(REQ_DELETE, 0,  32'h0, 1'b0);
    add_item(REQ_READ,   63, 32'h0, 1'b0);
    add_item(REQ_INSERT, 63, 32'hDEADBEEF, 1'b0);
    add_item(REQ_INSERT, 0,  32'hFFFFFFFF, 1'b0);
    add_item(REQ_INSERT, 1,  32'h12345678, 1'b0);
    add_item(REQ_APPEND, 63, 32'h00000000, 1'b0);
    add_item(REQ_INSERT, 1,  32'hA5A5A5A5, 1'b0);
    add_item(REQ_INSERT, 0,  32'h5A5A5A5A, 1'b0);
    for (n = 0; n < 5; n++) add_item(REQ_READ, n, 32'h0, 1'b0);
    add_item(REQ_DELETE, 1,  32'h0, 1'b0);
    add_item(REQ_DELETE, 2,  32'h0, 1'b0);
    add_item(REQ_DELETE, 0,  32'h0, 1'b0);
    add_item(REQ_READ,   0,  32'h0, 1'b0);
    add_item(REQ_DELETE, 1,  32'h0, 1'b0);
    add_item(REQ_DELETE, 0,  32'h0, 1'b0);
    add_item(REQ_APPEND, 0,  32'h80000001, 1'b0);
    add_item(REQ_DELETE, 0,  32'h0, 1'b0);

    // fill past capacity, drain past empty, then mixed phases
    n = issued;
    gen_phase(PH_FILL, 90, 1'b1);
    gen_phase(PH_DRAIN, 90, 1'b1);
    while (issued - n < RANDOM_ITEMS)
      gen_phase(phase_t'($urandom_range(PH_GROW, PH_MIX)), $urandom_range(60, 150),
                $urandom_range(0, 3) == 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted < issued) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
